/* hdl/sorted_matrix_binary_search_assert.svh */
// Assertion macros for the sorted-matrix search RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef SORTED_MATRIX_BINARY_SEARCH_ASSERT_SVH
`define SORTED_MATRIX_BINARY_SEARCH_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define SMBS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define SMBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/smbs_pkg.sv */
// Shared types and constants for the sorted-matrix binary search block.
// No dependencies; used by the controller, datapath and top level.
package smbs_pkg;

    // Field widths
    localparam int POS_W      = 10;
    localparam int VAL_W      = 32;
    localparam int CNT_W      = 6;
    localparam int S_TDATA_W  = 48;   // position + value, padded to bytes
    localparam int M_TDATA_W  = 8;    // found, padded to a byte

    // Operation codes carried on s_tuser
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Configuration register indexes
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic write;   // store the incoming element
        logic init;    // capture key, set search bounds
        logic read;    // issue a memory read at the midpoint
        logic step;    // compare probe with key, narrow the bounds
        logic emit;    // move the search outcome to the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;   // search range is exhausted
        logic hit;     // current probe equals the key
    } stat_t;

endpackage

/* hdl/sorted_matrix_binary_search.sv */
// Sorted-matrix binary search: searches a flat row-major store for a key.
// Channels: s_* input stream (s_tuser = op: 0 load, 1 search; s_tdata = position,
// value), m_* result stream (m_tdata bit 0 = found), cfg_* register writes
// (index 0 row_count, index 1 column_count, reset value 1 each, saturated to
// MAX_SIDE). A load writes one element (positions beyond the store are dropped)
// and gives no result. A search walks a binary search over rows*cols elements:
// an accept step, then a memory read and a compare for each probe, with p probes,
// p <= ceil(log2(rows*cols + 1)), then on a miss a check that sees the range
// exhausted, and last a load of the output register. The probe loop runs through
// the single registered memory read port.
// s_tready is high whenever no search is in progress; a finished result waits
// in the output register while new items are taken. If the receiver stalls
// with a result pending, the next search holds before its output stage until
// m_tready. Reset clears the control state and the configuration registers; the
// element store is not cleared, so every element must be loaded before it is
// searched. Depends on smbs_pkg, smbs_ctrl, smbs_datapath and smbs_ram.
module sorted_matrix_binary_search #(
    parameter int MAX_SIDE = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [smbs_pkg::CNT_W-1:0]     cfg_data,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [smbs_pkg::S_TDATA_W-1:0] s_tdata,  // [9:0] position, [41:10] value
    input  logic                           s_tuser,  // [0] op
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [smbs_pkg::M_TDATA_W-1:0] m_tdata   // [0] found
);
    import smbs_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  found_w;

    smbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    smbs_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .position  (s_tdata[POS_W-1:0]),
        .value     (s_tdata[POS_W+VAL_W-1:POS_W]),
        .cmd       (cmd),
        .stat      (stat),
        .found     (found_w)
    );

    // Result byte: found in bit 0, rest zero
    assign m_tdata = {(M_TDATA_W-1)'(0), found_w};

endmodule

/* hdl/smbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/smbs_datapath.sv */
// Datapath: element store, configuration registers, search bounds and key.
// Depends on smbs_pkg and smbs_ram.
module smbs_datapath #(
    parameter int MAX_SIDE = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [smbs_pkg::CNT_W-1:0] cfg_data,
    // incoming item payload
    input  logic [smbs_pkg::POS_W-1:0] position,
    input  logic [smbs_pkg::VAL_W-1:0] value,
    // control
    input  smbs_pkg::cmd_t             cmd,
    output smbs_pkg::stat_t            stat,
    output logic                       found
);
    import smbs_pkg::*;

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]    row_count_reg;
    logic [CNT_W-1:0]    column_count_reg;
    logic [SW-1:0]       rows_w;
    logic [SW-1:0]       cols_w;
    logic [2*SW-1:0]     elems_w;
    logic [CW-1:0]       lo_reg;
    logic [CW-1:0]       lo_next;
    logic [CW-1:0]       end_reg;
    logic [CW-1:0]       end_next;
    logic [CW:0]         mid_sum_w;
    logic [CW-1:0]       mid_w;
    logic [CW-1:0]       mid_reg;
    logic [VAL_W-1:0]    key_reg;
    logic                hit_reg;
    logic                found_reg;
    logic                store_ok_w;
    logic [VAL_W-1:0]    probe_w;
    logic [VAL_W-1:0]    rd_data_w;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= CNT_W'(1);
            column_count_reg <= CNT_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ROW_COUNT)
            begin
                row_count_reg <= cfg_data;
            end
            else if (cfg_index == REG_COLUMN_COUNT)
            begin
                column_count_reg <= cfg_data;
            end
        end
    end

    // Saturate counts to the store side, element count of the matrix
    assign rows_w  = (32'(row_count_reg) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(row_count_reg);
    assign cols_w  = (32'(column_count_reg) > MAX_SIDE) ? SW'(MAX_SIDE)
                                                         : SW'(column_count_reg);
    assign elems_w = rows_w * cols_w;

    // Midpoint of the half-open range [lo, end): floor((lo + end - 1) / 2)
    assign mid_sum_w = {1'b0, lo_reg} + {1'b0, end_reg} - (CW+1)'(1);
    assign mid_w     = mid_sum_w[CW:1];

    assign stat.empty = (lo_reg >= end_reg);
    assign probe_w    = rd_data_w;
    assign stat.hit   = (probe_w == key_reg);

    // Loads beyond the store are dropped
    assign store_ok_w = (32'(position) < DEPTH);

    smbs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.write && store_ok_w),
        .wr_addr (AW'(position)),
        .wr_data (value),
        .rd_en   (cmd.read),
        .rd_addr (mid_w[AW-1:0]),
        .rd_data (rd_data_w)
    );

    // Bound setup at search start and bound update after each probe
    always_comb
    begin
        lo_next  = lo_reg;
        end_next = end_reg;
        if (cmd.init)
        begin
            lo_next  = '0;
            end_next = CW'(elems_w);
        end
        else if (cmd.step)
        begin
            if ($signed(probe_w) < $signed(key_reg))
            begin
                lo_next = mid_reg + CW'(1);
            end
            else
            begin
                end_next = mid_reg;
            end
        end
    end

    // Search registers
    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        end_reg <= end_next;
        if (cmd.init)
        begin
            key_reg <= value;
            hit_reg <= 1'b0;
        end
        else if (cmd.step && stat.hit)
        begin
            hit_reg <= 1'b1;
        end
        if (cmd.read)
        begin
            mid_reg <= mid_w;
        end
        if (cmd.emit)
        begin
            found_reg <= hit_reg;
        end
    end

    assign found = found_reg;

endmodule

/* hdl/smbs_ctrl.sv */
// Controller FSM: input handshake, probe sequencing and output register valid.
// Depends on smbs_pkg and the assertion macro header.
`include "sorted_matrix_binary_search_assert.svh"

module smbs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic            s_op,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output smbs_pkg::cmd_t  cmd,
    input  smbs_pkg::stat_t stat
);
    import smbs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept_w;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept_w = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_w)
                begin
                    if (s_op == OP_LOAD)
                    begin
                        cmd.write = 1'b1;
                    end
                    else
                    begin
                        cmd.init   = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (stat.empty)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.read   = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                cmd.step   = 1'b1;
                state_next = stat.hit ? ST_DONE : ST_READ;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Checks
    `SMBS_ASSERT_NEXT(a_init_reads, cmd.init, state_reg == ST_READ, "search did not start")
    `SMBS_ASSERT_NEXT(a_read_cmp, cmd.read, state_reg == ST_CMP, "probe read not compared")
    `SMBS_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid_reg && state_reg == ST_IDLE,
                      "result not presented")
    `SMBS_ASSERT_ALWAYS(a_no_overwrite, !(cmd.emit && out_valid_reg && !m_tready),
                        "pending result overwritten")

endmodule
